// File: rtl/tickless_tick_timer_assert.svh
// Assertion macros used by the checker file of the tick timer.
`ifndef TICKLESS_TICK_TIMER_ASSERT_SVH
`define TICKLESS_TICK_TIMER_ASSERT_SVH

// Check a property on every rising clock edge, skipped while reset is high.
`define TTT_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tick timer assertion failed");

// Check a property on every rising clock edge, reset included.
`define TTT_ASSERT_ALL(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("tick timer assertion failed");

`endif

// File: rtl/ttt_pkg.sv
// Shared types, codes and constants of the tickless tick timer.
`default_nettype none

package ttt_pkg;

   // Tick scheduling constants
   localparam logic [63:0] MIN_DELAY_CYC = 64'd1000;
   localparam logic [31:0] MAX_CYC_VAL   = 32'h7FFF_FFFF;

   // Shift-subtract divider: one quotient bit per step
   localparam int unsigned DIV_STEPS = 64;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

   // Request kinds
   localparam logic [1:0] KIND_TICK    = 2'd0;
   localparam logic [1:0] KIND_TIMEOUT = 2'd1;
   localparam logic [1:0] KIND_QUERY   = 2'd2;

   // Register port
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 64;
   localparam logic [1:0]  REG_CYCLES_PER_TICK = 2'd0;
   localparam logic [1:0]  REG_TICKLESS_MODE   = 2'd1;
   localparam logic [1:0]  REG_COMPARE_LIMIT   = 2'd2;

   // Reset values of the registers
   localparam logic [30:0] CYCLES_PER_TICK_RST = 31'd1000;
   localparam logic        TICKLESS_MODE_RST   = 1'b1;
   localparam logic [63:0] COMPARE_LIMIT_RST   = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_DIV_TICK,
      S_TICK_MUL,
      S_TICK_ADV,
      S_TICK_NEXT,
      S_TICK_NEAR,
      S_TICK_PUSH,
      S_DIV_MAX,
      S_TO_REQ,
      S_TO_MUL,
      S_TO_SAT,
      S_TO_SETUP_RND,
      S_DIV_RND,
      S_TO_RND,
      S_TO_MARGIN,
      S_TO_PUSH,
      S_TO_ALARM,
      S_DIV_QRY,
      S_QRY_DONE,
      S_ALARM_DEC,
      S_ALARM_CHK,
      S_FINISH
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV_TICK,
      OP_DIV_MAX,
      OP_DIV_QRY,
      OP_DIV_RND,
      OP_DIV_STEP,
      OP_TICK_MUL,
      OP_TICK_ADV,
      OP_TICK_NEXT,
      OP_TICK_NEAR,
      OP_TICK_PUSH,
      OP_TO_REQ,
      OP_TO_MUL,
      OP_TO_SAT,
      OP_TO_RND,
      OP_TO_MARGIN,
      OP_TO_PUSH,
      OP_TO_ALARM,
      OP_QRY_DONE,
      OP_ALARM_DEC,
      OP_ALARM_CHK,
      OP_LOAD_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       tickless;
      logic       div_last;
   } dp_status_type;

   typedef struct packed {
      logic [30:0] cycles_per_tick;
      logic        tickless_mode;
      logic [63:0] compare_limit;
   } cfg_type;

   typedef struct packed {
      logic [31:0] announced_ticks;
      logic        alarm_written;
      logic [63:0] alarm_compare;
      logic [31:0] elapsed_ticks;
   } rsp_data_type;

endpackage

`default_nettype wire

// File: rtl/ttt_req_if.sv
// Request channel interface of the tick timer.
`default_nettype none

interface ttt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [63:0]        counter_now;
   logic signed [31:0] timeout_ticks;

   modport source (output valid, output kind, output counter_now, output timeout_ticks,
                   input ready);
   modport sink (input valid, input kind, input counter_now, input timeout_ticks,
                 output ready);
endinterface

`default_nettype wire

// File: rtl/ttt_rsp_if.sv
// Result channel interface of the tick timer.
`default_nettype none

interface ttt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] announced_ticks;
   logic        alarm_written;
   logic [63:0] alarm_compare;
   logic [31:0] elapsed_ticks;

   modport source (output valid, output announced_ticks, output alarm_written,
                   output alarm_compare, output elapsed_ticks, input ready);
   modport sink (input valid, input announced_ticks, input alarm_written,
                 input alarm_compare, input elapsed_ticks, output ready);
endinterface

`default_nettype wire

// File: rtl/ttt_csr.sv
// Configuration register file of the tick timer behind an APB-style port.
`default_nettype none

module ttt_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [ttt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [ttt_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [ttt_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready,
   output ttt_pkg::cfg_type                     cfg
);

   logic [30:0] cpt_ff, cpt_in;
   logic        mode_ff, mode_in;
   logic [63:0] limit_ff, limit_in;
   logic        wr_en;
   logic [1:0]  reg_sel;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[4:3];
   assign csr_pready = 1'b1;

   // Decode the write transfer
   always_comb begin
      cpt_in   = cpt_ff;
      mode_in  = mode_ff;
      limit_in = limit_ff;
      if (wr_en) begin
         unique case (reg_sel)
            ttt_pkg::REG_CYCLES_PER_TICK: cpt_in   = csr_pwdata[30:0];
            ttt_pkg::REG_TICKLESS_MODE:   mode_in  = csr_pwdata[0];
            ttt_pkg::REG_COMPARE_LIMIT:   limit_in = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpt_ff   <= ttt_pkg::CYCLES_PER_TICK_RST;
         mode_ff  <= ttt_pkg::TICKLESS_MODE_RST;
         limit_ff <= ttt_pkg::COMPARE_LIMIT_RST;
      end else begin
         cpt_ff   <= cpt_in;
         mode_ff  <= mode_in;
         limit_ff <= limit_in;
      end
   end

   // Return the addressed register
   always_comb begin
      unique case (reg_sel)
         ttt_pkg::REG_CYCLES_PER_TICK: csr_prdata = {33'd0, cpt_ff};
         ttt_pkg::REG_TICKLESS_MODE:   csr_prdata = {63'd0, mode_ff};
         ttt_pkg::REG_COMPARE_LIMIT:   csr_prdata = limit_ff;
         default:                      csr_prdata = '0;
      endcase
   end

   assign cfg.cycles_per_tick = cpt_ff;
   assign cfg.tickless_mode   = mode_ff;
   assign cfg.compare_limit   = limit_ff;

endmodule

`default_nettype wire

// File: rtl/ttt_ctrl.sv
// Sequencer of the tick timer: steps the datapath and owns the handshakes.
`default_nettype none

module ttt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire ttt_pkg::dp_status_type status,
   output ttt_pkg::ctrl_cmd_type      cmd
);

   ttt_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ttt_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttt_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath command
   always_comb begin
      state_in = state_ff;
      cmd.op   = ttt_pkg::OP_NONE;
      unique case (state_ff)
         ttt_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.op   = ttt_pkg::OP_LOAD;
               state_in = ttt_pkg::S_DECODE;
            end
         end
         ttt_pkg::S_DECODE: begin
            priority if (status.kind == ttt_pkg::KIND_TICK) begin
               cmd.op   = ttt_pkg::OP_DIV_TICK;
               state_in = ttt_pkg::S_DIV_TICK;
            end else if (status.kind == ttt_pkg::KIND_TIMEOUT && status.tickless) begin
               cmd.op   = ttt_pkg::OP_DIV_MAX;
               state_in = ttt_pkg::S_DIV_MAX;
            end else if (status.kind == ttt_pkg::KIND_QUERY && status.tickless) begin
               cmd.op   = ttt_pkg::OP_DIV_QRY;
               state_in = ttt_pkg::S_DIV_QRY;
            end else begin
               state_in = ttt_pkg::S_FINISH;
            end
         end
         // Tick event: whole ticks, boundary advance, periodic compare
         ttt_pkg::S_DIV_TICK: begin
            cmd.op = ttt_pkg::OP_DIV_STEP;
            if (status.div_last) state_in = ttt_pkg::S_TICK_MUL;
         end
         ttt_pkg::S_TICK_MUL: begin
            cmd.op   = ttt_pkg::OP_TICK_MUL;
            state_in = ttt_pkg::S_TICK_ADV;
         end
         ttt_pkg::S_TICK_ADV: begin
            cmd.op   = ttt_pkg::OP_TICK_ADV;
            state_in = status.tickless ? ttt_pkg::S_FINISH : ttt_pkg::S_TICK_NEXT;
         end
         ttt_pkg::S_TICK_NEXT: begin
            cmd.op   = ttt_pkg::OP_TICK_NEXT;
            state_in = ttt_pkg::S_TICK_NEAR;
         end
         ttt_pkg::S_TICK_NEAR: begin
            cmd.op   = ttt_pkg::OP_TICK_NEAR;
            state_in = ttt_pkg::S_TICK_PUSH;
         end
         ttt_pkg::S_TICK_PUSH: begin
            cmd.op   = ttt_pkg::OP_TICK_PUSH;
            state_in = ttt_pkg::S_ALARM_DEC;
         end
         // Timeout request: clamp, saturate, round to a boundary
         ttt_pkg::S_DIV_MAX: begin
            cmd.op = ttt_pkg::OP_DIV_STEP;
            if (status.div_last) state_in = ttt_pkg::S_TO_REQ;
         end
         ttt_pkg::S_TO_REQ: begin
            cmd.op   = ttt_pkg::OP_TO_REQ;
            state_in = ttt_pkg::S_TO_MUL;
         end
         ttt_pkg::S_TO_MUL: begin
            cmd.op   = ttt_pkg::OP_TO_MUL;
            state_in = ttt_pkg::S_TO_SAT;
         end
         ttt_pkg::S_TO_SAT: begin
            cmd.op   = ttt_pkg::OP_TO_SAT;
            state_in = ttt_pkg::S_TO_SETUP_RND;
         end
         ttt_pkg::S_TO_SETUP_RND: begin
            cmd.op   = ttt_pkg::OP_DIV_RND;
            state_in = ttt_pkg::S_DIV_RND;
         end
         ttt_pkg::S_DIV_RND: begin
            cmd.op = ttt_pkg::OP_DIV_STEP;
            if (status.div_last) state_in = ttt_pkg::S_TO_RND;
         end
         ttt_pkg::S_TO_RND: begin
            cmd.op   = ttt_pkg::OP_TO_RND;
            state_in = ttt_pkg::S_TO_MARGIN;
         end
         ttt_pkg::S_TO_MARGIN: begin
            cmd.op   = ttt_pkg::OP_TO_MARGIN;
            state_in = ttt_pkg::S_TO_PUSH;
         end
         ttt_pkg::S_TO_PUSH: begin
            cmd.op   = ttt_pkg::OP_TO_PUSH;
            state_in = ttt_pkg::S_TO_ALARM;
         end
         ttt_pkg::S_TO_ALARM: begin
            cmd.op   = ttt_pkg::OP_TO_ALARM;
            state_in = ttt_pkg::S_ALARM_DEC;
         end
         // Elapsed query
         ttt_pkg::S_DIV_QRY: begin
            cmd.op = ttt_pkg::OP_DIV_STEP;
            if (status.div_last) state_in = ttt_pkg::S_QRY_DONE;
         end
         ttt_pkg::S_QRY_DONE: begin
            cmd.op   = ttt_pkg::OP_QRY_DONE;
            state_in = ttt_pkg::S_FINISH;
         end
         // Compare programming shared by tick and timeout
         ttt_pkg::S_ALARM_DEC: begin
            cmd.op   = ttt_pkg::OP_ALARM_DEC;
            state_in = ttt_pkg::S_ALARM_CHK;
         end
         ttt_pkg::S_ALARM_CHK: begin
            cmd.op   = ttt_pkg::OP_ALARM_CHK;
            state_in = ttt_pkg::S_FINISH;
         end
         // Hand the result to the output register once it is free
         ttt_pkg::S_FINISH: begin
            if (out_free) begin
               cmd.op   = ttt_pkg::OP_LOAD_OUT;
               state_in = ttt_pkg::S_IDLE;
            end
         end
         default: state_in = ttt_pkg::S_IDLE;
      endcase
   end

   // Hold the result valid until its transfer
   assign rsp_valid_in = (cmd.op == ttt_pkg::OP_LOAD_OUT) || (rsp_valid_ff && !rsp_ready);

endmodule

`default_nettype wire

// File: rtl/ttt_dpath.sv
// Datapath of the tick timer: boundary, shift-subtract divider, multiplier, result.
`default_nettype none

module ttt_dpath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ttt_pkg::cfg_type       cfg,
   input  wire logic [1:0]             req_kind,
   input  wire logic [63:0]            req_counter_now,
   input  wire logic signed [31:0]     req_timeout_ticks,
   input  wire ttt_pkg::ctrl_cmd_type  cmd,
   output ttt_pkg::dp_status_type      status,
   output ttt_pkg::rsp_data_type       rsp_data
);

   logic [30:0] tlen;
   logic [1:0]  kind_ff, kind_in;
   logic [63:0] now_ff, now_in;
   logic [31:0] raw_ff, raw_in;
   logic [63:0] lb_ff, lb_in;
   logic [63:0] num_ff, num_in;
   logic [30:0] rem_ff, rem_in;
   logic [ttt_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] cyc_ff, cyc_in;
   logic [31:0] adj_ff, adj_in;
   logic        flag_ff, flag_in;
   ttt_pkg::rsp_data_type res_ff, res_in;
   ttt_pkg::rsp_data_type out_ff, out_in;

   logic [31:0] trial;
   logic        trial_ge;
   logic [31:0] trial_sub;
   logic [31:0] mul_a;
   logic [62:0] mprod;
   logic [31:0] maxq;
   logic [31:0] raw_m1;
   logic [31:0] req_clamped;
   logic [31:0] sat_lim;
   logic [31:0] margin;

   // A zero tick length counts as one cycle
   assign tlen = (cfg.cycles_per_tick == 31'd0) ? 31'd1 : cfg.cycles_per_tick;

   // One restoring division step
   assign trial     = {rem_ff, num_ff[63]};
   assign trial_ge  = trial >= {1'b0, tlen};
   assign trial_sub = trial - {1'b0, tlen};

   // Shared 32x31 multiplier
   assign mul_a = (cmd.op == ttt_pkg::OP_TO_MUL) ? cyc_ff : num_ff[31:0];
   assign mprod = {31'd0, mul_a} * {32'd0, tlen};

   // Requested ticks less one, clamped to the largest tick count
   assign maxq   = num_ff[31:0];
   assign raw_m1 = raw_ff - 32'd1;
   always_comb begin
      priority if (raw_ff == 32'hFFFF_FFFF) begin
         req_clamped = (maxq == 32'd0) ? 32'd0 : maxq - 32'd1;
      end else if (raw_ff[31] || raw_ff == 32'd0) begin
         req_clamped = 32'd0;
      end else begin
         req_clamped = (raw_m1 > maxq) ? maxq : raw_m1;
      end
   end

   assign sat_lim = ttt_pkg::MAX_CYC_VAL - adj_ff;
   assign margin  = cyc_ff + lb_ff[31:0] - now_ff[31:0];

   // Execute the command
   always_comb begin
      kind_in = kind_ff;
      now_in  = now_ff;
      raw_in  = raw_ff;
      lb_in   = lb_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      cyc_in  = cyc_ff;
      adj_in  = adj_ff;
      flag_in = flag_ff;
      res_in  = res_ff;
      out_in  = out_ff;
      unique case (cmd.op)
         ttt_pkg::OP_NONE: ;
         ttt_pkg::OP_LOAD: begin
            kind_in = req_kind;
            now_in  = req_counter_now;
            raw_in  = $unsigned(req_timeout_ticks);
            res_in  = '0;
         end
         ttt_pkg::OP_DIV_TICK: begin
            num_in = now_ff - lb_ff;
            rem_in = '0;
            cnt_in = '0;
         end
         ttt_pkg::OP_DIV_MAX: begin
            num_in = {32'd0, ttt_pkg::MAX_CYC_VAL - {1'b0, tlen}};
            rem_in = '0;
            cnt_in = '0;
         end
         ttt_pkg::OP_DIV_QRY: begin
            num_in = {32'd0, now_ff[31:0] - lb_ff[31:0]};
            rem_in = '0;
            cnt_in = '0;
         end
         ttt_pkg::OP_DIV_RND: begin
            num_in = {32'd0, cyc_ff};
            rem_in = '0;
            cnt_in = '0;
         end
         ttt_pkg::OP_DIV_STEP: begin
            num_in = {num_ff[62:0], trial_ge};
            rem_in = trial_ge ? trial_sub[30:0] : trial[30:0];
            cnt_in = cnt_ff + 1'b1;
         end
         ttt_pkg::OP_TICK_MUL: begin
            acc_in = {1'b0, mprod};
            res_in.announced_ticks = cfg.tickless_mode ? num_ff[31:0] : 32'd1;
         end
         ttt_pkg::OP_TICK_ADV:  lb_in  = lb_ff + acc_ff;
         ttt_pkg::OP_TICK_NEXT: acc_in = lb_ff + {33'd0, tlen};
         ttt_pkg::OP_TICK_NEAR: flag_in = (acc_ff - now_ff) < ttt_pkg::MIN_DELAY_CYC;
         ttt_pkg::OP_TICK_PUSH: begin
            if (flag_ff) acc_in = acc_ff + {33'd0, tlen};
         end
         ttt_pkg::OP_TO_REQ: cyc_in = req_clamped;
         ttt_pkg::OP_TO_MUL: begin
            cyc_in = mprod[31:0];
            adj_in = now_ff[31:0] - lb_ff[31:0] + {1'b0, tlen} - 32'd1;
         end
         ttt_pkg::OP_TO_SAT: begin
            cyc_in = (cyc_ff <= sat_lim) ? cyc_ff + adj_ff : ttt_pkg::MAX_CYC_VAL;
         end
         ttt_pkg::OP_TO_RND: cyc_in = mprod[31:0];
         ttt_pkg::OP_TO_MARGIN: begin
            flag_in = margin[31] || (margin < ttt_pkg::MIN_DELAY_CYC[31:0]);
         end
         ttt_pkg::OP_TO_PUSH: begin
            if (flag_ff) cyc_in = cyc_ff + {1'b0, tlen};
         end
         ttt_pkg::OP_TO_ALARM:  acc_in = {32'd0, cyc_ff} + lb_ff;
         ttt_pkg::OP_QRY_DONE:  res_in.elapsed_ticks = num_ff[31:0];
         ttt_pkg::OP_ALARM_DEC: acc_in = acc_ff - 64'd1;
         ttt_pkg::OP_ALARM_CHK: begin
            if (acc_ff <= cfg.compare_limit) begin
               res_in.alarm_written = 1'b1;
               res_in.alarm_compare = acc_ff;
            end
         end
         ttt_pkg::OP_LOAD_OUT: out_in = res_ff;
         default: ;
      endcase
   end

   // Boundary count is the only state with a reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         lb_ff <= '0;
      end else begin
         lb_ff <= lb_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      now_ff  <= now_in;
      raw_ff  <= raw_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      cyc_ff  <= cyc_in;
      adj_ff  <= adj_in;
      flag_ff <= flag_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   assign status.kind     = kind_ff;
   assign status.tickless = cfg.tickless_mode;
   assign status.div_last = (cnt_ff == ttt_pkg::DIV_LAST_STEP);
   assign rsp_data        = out_ff;

endmodule

`default_nettype wire

// File: rtl/tickless_tick_timer.sv
// Top level of the tickless tick timer: register file, sequencer and datapath.
//
//   channel   direction  handshake              payload
//   req_chan  in         valid/ready            kind, counter_now, timeout_ticks
//   rsp_chan  out        valid/ready            announced_ticks, alarm_written,
//                                               alarm_compare, elapsed_ticks
//   csr_*     in/out     psel/penable/pready    paddr, pwdata, prdata
//
// One item at a time. The 64-step shift-subtract divider runs once for a tick or a
// query and twice for a timeout; an ignored item skips it. A new item is taken while
// the previous result waits in the output register; a finished item waits for that
// register to empty.
// Synchronous reset clears the boundary count, the registers and output valid.
`default_nettype none

module tickless_tick_timer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   ttt_req_if.sink                              req_chan,
   ttt_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [ttt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [ttt_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [ttt_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   ttt_pkg::cfg_type       cfg;
   ttt_pkg::ctrl_cmd_type  cmd;
   ttt_pkg::dp_status_type status;
   ttt_pkg::rsp_data_type  rsp_data;
   logic                   req_ready;
   logic                   rsp_valid;

   ttt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ttt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ttt_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_kind          (req_chan.kind),
      .req_counter_now   (req_chan.counter_now),
      .req_timeout_ticks (req_chan.timeout_ticks),
      .cmd               (cmd),
      .status            (status),
      .rsp_data          (rsp_data)
   );

   // Drive the channel handshakes and result payload
   assign req_chan.ready           = req_ready;
   assign rsp_chan.valid           = rsp_valid;
   assign rsp_chan.announced_ticks = rsp_data.announced_ticks;
   assign rsp_chan.alarm_written   = rsp_data.alarm_written;
   assign rsp_chan.alarm_compare   = rsp_data.alarm_compare;
   assign rsp_chan.elapsed_ticks   = rsp_data.elapsed_ticks;

endmodule

`default_nettype wire

// File: rtl/ttt_checker.sv
// Port-level assertions of the tick timer and their bind to the top level.
`default_nettype none

`include "tickless_tick_timer_assert.svh"

module ttt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_announced_ticks,
   input wire logic        rsp_alarm_written,
   input wire logic [63:0] rsp_alarm_compare,
   input wire logic [31:0] rsp_elapsed_ticks
);

   // A stalled result stays offered
   `TTT_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // A stalled result keeps its payload
   `TTT_ASSERT_RST(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_announced_ticks) && $stable(rsp_alarm_written) && $stable(rsp_alarm_compare) && $stable(rsp_elapsed_ticks))

   // The engine is busy right after it takes an item
   `TTT_ASSERT_RST(a_busy_after_take, clock, reset, req_valid && req_ready |=> !req_ready)

   // No compare value without a write, and never both tick counts at once
   `TTT_ASSERT_RST(a_rsp_fields, clock, reset, rsp_valid |-> (rsp_alarm_written || rsp_alarm_compare == 64'd0) && (rsp_announced_ticks == 32'd0 || rsp_elapsed_ticks == 32'd0))

   // Reset drops any pending result
   `TTT_ASSERT_ALL(a_reset_clears, clock, reset |=> !rsp_valid)

endmodule

bind tickless_tick_timer ttt_checker u_ttt_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_announced_ticks (rsp_chan.announced_ticks),
   .rsp_alarm_written   (rsp_chan.alarm_written),
   .rsp_alarm_compare   (rsp_chan.alarm_compare),
   .rsp_elapsed_ticks   (rsp_chan.elapsed_ticks)
);

`default_nettype wire
